// ----- rtl/core/pmd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmd_pkg
// Types and constants shared by the ps/2 mouse packet decoder modules.
// ----------------------------------------------------------------------------
package pmd_pkg;

    localparam logic [7:0] ACK_BYTE = 8'hFA;

    localparam logic [1:0] EV_DOWN   = 2'd0;
    localparam logic [1:0] EV_UP     = 2'd1;
    localparam logic [1:0] EV_MOVE_X = 2'd2;
    localparam logic [1:0] EV_MOVE_Y = 2'd3;

    localparam int NUM_EVENTS = 5;

    // one decoded packet, as handed from the front to the back
    typedef struct packed {
        logic [2:0] changed;  // buttons whose state flipped
        logic [2:0] now;      // new button state
        logic [8:0] dx;
        logic [8:0] dy;
    } t_pkt;

endpackage

// ----- rtl/core/pmd_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmd_front
// Byte collector: drops ack bytes at packet start, gathers packets, filters
// overflow, diffs the button state; pushes one record per packet with events.
// ----------------------------------------------------------------------------
module pmd_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_acc,
    input  logic [7:0]       i_rx_byte,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_data,
    output logic             o_push,
    output pmd_pkg::t_pkt    o_pkt
);
    import pmd_pkg::*;

    logic [2:0] r_pkt_size;
    logic [1:0] r_cnt, n_cnt;
    logic [7:0] r_b0, n_b0;
    logic [7:0] r_b1, n_b1;
    logic [7:0] r_b2, n_b2;
    logic [2:0] r_btn, n_btn;

    logic       is_ack;
    logic       complete;
    logic [7:0] y_byte;
    t_pkt       pkt;
    logic       push;

    assign is_ack   = (r_cnt == 2'd0) && (i_rx_byte == ACK_BYTE);
    // size 4..7 means four bytes, anything else three
    assign complete = (r_cnt == 2'd3) || ((r_cnt == 2'd2) && !r_pkt_size[2]);
    assign y_byte   = (r_cnt == 2'd2) ? i_rx_byte : r_b2;

    always_comb begin
        pkt.now     = r_b0[2:0];
        pkt.changed = r_b0[2:0] ^ r_btn;
        pkt.dx      = {r_b0[4], r_b1};
        pkt.dy      = {r_b0[5], y_byte};
    end

    always_comb begin
        n_cnt = r_cnt;
        n_b0  = r_b0;
        n_b1  = r_b1;
        n_b2  = r_b2;
        n_btn = r_btn;
        push  = 1'b0;
        if (i_acc && !is_ack) begin
            case (r_cnt)
                2'd0: begin
                    n_b0 = i_rx_byte;
                    n_b1 = 8'd0;
                    n_b2 = 8'd0;
                end
                2'd1: n_b1 = i_rx_byte;
                2'd2: n_b2 = i_rx_byte;
                default: ;
            endcase
            if (complete) begin
                n_cnt = 2'd0;
                if (r_b0[7:6] == 2'b00) begin
                    n_btn = r_b0[2:0];
                    push  = (pkt.changed != 3'd0) || (r_b1 != 8'd0) || (y_byte != 8'd0);
                end
            end else begin
                n_cnt = r_cnt + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pkt_size <= 3'd3;
            r_cnt      <= 2'd0;
            r_btn      <= 3'd0;
            r_b0       <= 8'd0;
            r_b1       <= 8'd0;
            r_b2       <= 8'd0;
        end else begin
            if (i_cfg_we) begin
                r_pkt_size <= i_cfg_data;
            end
            r_cnt <= n_cnt;
            r_btn <= n_btn;
            r_b0  <= n_b0;
            r_b1  <= n_b1;
            r_b2  <= n_b2;
        end
    end

    assign o_push = push;
    assign o_pkt  = pkt;

endmodule

// ----- rtl/core/pmd_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmd_queue
// Two-entry packet record queue between the front and the back.
// ----------------------------------------------------------------------------
module pmd_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  pmd_pkg::t_pkt    i_pkt,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_nonempty,
    output pmd_pkg::t_pkt    o_pkt
);
    import pmd_pkg::*;

    t_pkt       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_pkt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    assign o_full     = (r_count == 2'd2);
    assign o_nonempty = (r_count != 2'd0);
    assign o_pkt      = r_mem[r_rp];

endmodule

// ----- rtl/core/pmd_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmd_back
// Event sequencer: walks the pending events of one packet record, one per
// cycle while the output is not stalled, into the output register.
// ----------------------------------------------------------------------------
module pmd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_nonempty,
    input  pmd_pkg::t_pkt    i_q_pkt,
    output logic             o_pop,
    input  logic             i_stall,
    output logic             o_valid,
    output logic [1:0]       o_event_kind,
    output logic [1:0]       o_button,
    output logic signed [8:0] o_delta,
    output logic             o_last
);
    import pmd_pkg::*;

    t_pkt                  r_rec;
    logic [NUM_EVENTS-1:0] r_pend;
    logic [NUM_EVENTS-1:0] sel;
    logic [NUM_EVENTS-1:0] pend_after;
    logic                  adv;
    logic                  fire;
    logic                  pop;

    logic                  r_ov;
    logic [1:0]            r_kind, n_kind;
    logic [1:0]            r_btn, n_btn;
    logic [8:0]            r_delta, n_delta;
    logic                  r_last;

    // lowest pending event first: left, right, middle, x, y
    always_comb begin
        sel     = '0;
        n_kind  = EV_DOWN;
        n_btn   = 2'd0;
        n_delta = 9'd0;
        if (r_pend[0]) begin
            sel[0] = 1'b1;
            n_kind = r_rec.now[0] ? EV_DOWN : EV_UP;
        end else if (r_pend[1]) begin
            sel[1] = 1'b1;
            n_kind = r_rec.now[1] ? EV_DOWN : EV_UP;
            n_btn  = 2'd1;
        end else if (r_pend[2]) begin
            sel[2] = 1'b1;
            n_kind = r_rec.now[2] ? EV_DOWN : EV_UP;
            n_btn  = 2'd2;
        end else if (r_pend[3]) begin
            sel[3]  = 1'b1;
            n_kind  = EV_MOVE_X;
            n_delta = r_rec.dx;
        end else if (r_pend[4]) begin
            sel[4]  = 1'b1;
            n_kind  = EV_MOVE_Y;
            n_delta = r_rec.dy;
        end
    end

    assign pend_after = r_pend & ~sel;
    assign adv        = !r_ov || !i_stall;
    assign fire       = adv && (r_pend != '0);
    assign pop        = i_q_nonempty && ((r_pend == '0) || (fire && (pend_after == '0)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (pop) begin
                r_pend <= {i_q_pkt.dy[7:0] != 8'd0, i_q_pkt.dx[7:0] != 8'd0,
                           i_q_pkt.changed};
            end else if (fire) begin
                r_pend <= pend_after;
            end
            if (adv) begin
                r_ov <= fire;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_rec <= i_q_pkt;
        end
        if (fire) begin
            r_kind  <= n_kind;
            r_btn   <= n_btn;
            r_delta <= n_delta;
            r_last  <= (pend_after == '0);
        end
    end

    assign o_pop        = pop;
    assign o_valid      = r_ov;
    assign o_event_kind = r_kind;
    assign o_button     = r_btn;
    assign o_delta      = $signed(r_delta);
    assign o_last       = r_last;

`ifndef ASSERT_OFF
    a_fire_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_ov)
        else $error("issued event not presented");
    a_pop_when_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> ((r_pend == '0) || (pend_after == '0)))
        else $error("record loaded over pending events");
    a_record_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> (r_pend != '0))
        else $error("queued record carries no event");
`endif

endmodule

// ----- rtl/core/ps2_mouse_packet_decoder_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2_mouse_packet_decoder_core
// Decodes ps/2 mouse bytes into button and move events.
// ----------------------------------------------------------------------------
// path: last byte -> packet queue -> pending-event register -> output register
// throughput: one byte per cycle in, one event per cycle out unless i_stall;
//   the input stalls only when the two-entry packet queue is full
// reset: synchronous active low; packet size 3, byte count 0, buttons released
module ps2_mouse_packet_decoder_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [7:0]        i_rx_byte,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [1:0]        o_event_kind,
    output logic [1:0]        o_button,
    output logic signed [8:0] o_delta,
    output logic              o_last,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [2:0]        i_cfg_data
);
    import pmd_pkg::*;

    logic acc;
    logic push;
    logic pop;
    logic q_full;
    logic q_nonempty;
    t_pkt f_pkt;
    t_pkt q_pkt;

    assign o_stall     = q_full;
    assign acc         = i_valid && !q_full;
    assign o_cfg_ready = 1'b1;

    pmd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_acc      (acc),
        .i_rx_byte  (i_rx_byte),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .o_push     (push),
        .o_pkt      (f_pkt)
    );

    pmd_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_pkt      (f_pkt),
        .i_pop      (pop),
        .o_full     (q_full),
        .o_nonempty (q_nonempty),
        .o_pkt      (q_pkt)
    );

    pmd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_nonempty (q_nonempty),
        .i_q_pkt      (q_pkt),
        .o_pop        (pop),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_event_kind (o_event_kind),
        .o_button     (o_button),
        .o_delta      (o_delta),
        .o_last       (o_last)
    );

endmodule

// ----- sim/ps2_mouse_event_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2_mouse_event_checker
// Watches the byte, config and event channels of the mouse packet decoder,
// predicts the button and move events that every packet should produce and
// compares each event taken from the block against the oldest prediction.
// ----------------------------------------------------------------------------
module ps2_mouse_event_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // byte channel
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [7:0] i_rx_byte,
    // event channel
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [1:0] i_event_kind,
    input  logic [1:0] i_button,
    input  logic [8:0] i_delta,
    input  logic       i_last,
    // packet size register
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic [2:0] i_cfg_data,
    output int         o_pending,
    output int         o_errors
);
    import pmd_pkg::*;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] btn;
        logic [8:0] delta;
        logic       last;
    } t_mouse_event;

    t_mouse_event expected_events[$];
    t_mouse_event want;

    // shadow of the decoder state
    logic [2:0]  size_reg;
    logic [1:0]  bytes_seen;
    logic [23:0] pkt_hold;
    logic [2:0]  btn_state;

    int mismatches = 0;
    int queued     = 0;

    assign o_errors  = mismatches;
    assign o_pending = queued;

    task automatic report_mismatch(input string what);
        if (mismatches < 50)
            $display("mismatch at %0t ns: %s", $time, what);
        mismatches++;
    endtask

    // feed one accepted byte and queue the events it completes
    task automatic decode_byte(input logic [7:0] b);
        logic [2:0]   need;
        logic [7:0]   head;
        t_mouse_event batch[$];
        int           k;
        need = size_reg[2] ? 3'd4 : 3'd3;
        if (bytes_seen == 2'd0 && b == ACK_BYTE)
            return;
        case (bytes_seen)
            2'd0: pkt_hold = {b, 16'h0000};
            2'd1: pkt_hold[15:8] = b;
            2'd2: pkt_hold[7:0] = b;
            default: ;  // wheel byte is dropped
        endcase
        if ({1'b0, bytes_seen} + 3'd1 < need) begin
            bytes_seen = bytes_seen + 2'd1;
            return;
        end
        bytes_seen = 2'd0;
        head = pkt_hold[23:16];
        if (head[7:6] != 2'b00) begin
            pkt_hold = '0;
            return;
        end
        for (k = 0; k < 3; k++) begin
            if (head[k] && !btn_state[k]) begin
                batch.push_back('{EV_DOWN, 2'(k), 9'd0, 1'b0});
                btn_state[k] = 1'b1;
            end else if (!head[k] && btn_state[k]) begin
                batch.push_back('{EV_UP, 2'(k), 9'd0, 1'b0});
                btn_state[k] = 1'b0;
            end
        end
        if (pkt_hold[15:8] != 8'h00)
            batch.push_back('{EV_MOVE_X, 2'd0, {head[4], pkt_hold[15:8]}, 1'b0});
        if (pkt_hold[7:0] != 8'h00)
            batch.push_back('{EV_MOVE_Y, 2'd0, {head[5], pkt_hold[7:0]}, 1'b0});
        pkt_hold = '0;
        if (batch.size() > 0)
            batch[batch.size() - 1].last = 1'b1;
        foreach (batch[j])
            expected_events.push_back(batch[j]);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            size_reg   = 3'd3;
            bytes_seen = 2'd0;
            pkt_hold   = '0;
            btn_state  = 3'b000;
            expected_events.delete();
        end else begin
            // an event never comes from a byte taken at the same edge
            if (i_out_valid && !i_out_stall) begin
                if (expected_events.size() == 0) begin
                    report_mismatch($sformatf("unexpected event kind %0d button %0d delta %0d",
                                              i_event_kind, i_button, i_delta));
                end else begin
                    want = expected_events.pop_front();
                    if (i_event_kind !== want.kind)
                        report_mismatch($sformatf("event_kind got %0d want %0d",
                                                  i_event_kind, want.kind));
                    if (i_button !== want.btn)
                        report_mismatch($sformatf("button got %0d want %0d",
                                                  i_button, want.btn));
                    if (i_delta !== want.delta)
                        report_mismatch($sformatf("delta got 'h%0h want 'h%0h",
                                                  i_delta, want.delta));
                    if (i_last !== want.last)
                        report_mismatch($sformatf("last got %0b want %0b",
                                                  i_last, want.last));
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                size_reg = i_cfg_data;
            if (i_in_valid && !i_in_stall)
                decode_byte(i_rx_byte);
        end
        queued <= expected_events.size();
    end

endmodule

// ----- sim/tb_ps2_mouse_packet_decoder_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ps2_mouse_packet_decoder_core
// Sends mouse bytes to the packet decoder: a directed set of packets first
// (acknowledge bytes, all buttons, signed moves, overflow, empty packets,
// wheel byte, size changed mid packet), then random packets and noise under
// several packet sizes, with random idle cycles on both sides. The event
// checker beside the block predicts and compares; this module gives verdict.
// ----------------------------------------------------------------------------
module tb_ps2_mouse_packet_decoder_core;
    import pmd_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int BYTES_PER_RUN = 65;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic [7:0]  i_rx_byte   = 8'h00;
    logic        i_stall     = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [2:0]  i_cfg_data  = 3'd0;
    logic        o_stall;
    logic        o_valid;
    logic [1:0]  o_event_kind;
    logic [1:0]  o_button;
    logic signed [8:0] o_delta;
    logic        o_last;
    logic        o_cfg_ready;

    logic        calm = 1'b0;   // no idling on either side while set
    int          cycle_count = 0;
    int          pending;
    int          errors;

    logic [2:0]  size_plan [6];
    logic [7:0]  head;
    logic        wheel;
    int          sent;
    int          roll;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    ps2_mouse_packet_decoder_core i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_rx_byte    (i_rx_byte),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_event_kind (o_event_kind),
        .o_button     (o_button),
        .o_delta      (o_delta),
        .o_last       (o_last),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    ps2_mouse_event_checker u_event_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_rx_byte    (i_rx_byte),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_event_kind (o_event_kind),
        .i_button     (o_button),
        .i_delta      (o_delta),
        .i_last       (o_last),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_pending    (pending),
        .o_errors     (errors)
    );

    always @(posedge i_clk) begin
        i_stall <= !calm && ($urandom_range(0, 99) < 10);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // one byte request, held until the block takes it
    task automatic send_byte(input logic [7:0] b);
        if (!calm && $urandom_range(0, 99) < 10) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (o_stall);
    endtask

    // wait until every predicted event is out, plus the block's latency
    task automatic drain_events();
        do @(posedge i_clk); while (pending != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_size(input logic [2:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] move_byte();
        if ($urandom_range(0, 4) == 0)
            return 8'h00;
        return 8'($urandom_range(1, 255));
    endfunction

    initial begin
        size_plan = '{3'd7, 3'd0, 3'd4, 3'd3, 3'd0, 3'd0};
        size_plan[4] = 3'($urandom_range(0, 7));
        size_plan[5] = 3'($urandom_range(0, 7));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // acknowledge at packet start, then ack value used as x data
        send_byte(ACK_BYTE);
        send_byte(8'h07); send_byte(ACK_BYTE); send_byte(8'h00);
        // all buttons up, negative moves
        send_byte(8'h30); send_byte(8'hFF); send_byte(8'h80);
        // x overflow and y overflow are dropped
        send_byte(8'h41); send_byte(8'h01); send_byte(8'h01);
        send_byte(8'h81); send_byte(8'h00); send_byte(8'h00);
        // empty packet
        send_byte(8'h00); send_byte(8'h00); send_byte(8'h00);
        i_valid <= 1'b0;
        drain_events();

        // wheel packet, then three bytes left open across a size change
        write_size(3'd4);
        send_byte(8'h02); send_byte(8'h05); send_byte(8'h06); send_byte(8'h7F);
        send_byte(8'h01); send_byte(8'h00); send_byte(8'h00);
        i_valid <= 1'b0;
        drain_events();
        write_size(3'd3);
        send_byte(8'hAA);
        i_valid <= 1'b0;

        for (int ph = 0; ph < 6; ph++) begin
            drain_events();
            write_size(size_plan[ph]);
            wheel = size_plan[ph][2];
            calm <= (ph == 2);
            sent = 0;
            while (sent < BYTES_PER_RUN) begin
                roll = $urandom_range(0, 99);
                if (roll < 6) begin
                    send_byte(ACK_BYTE);
                end else if (roll < 14) begin
                    send_byte(8'($urandom_range(0, 255)));
                    sent++;
                end else begin
                    head = 8'($urandom_range(0, 255));
                    if ($urandom_range(0, 9) != 0)
                        head[7:6] = 2'b00;
                    send_byte(head);
                    send_byte(move_byte());
                    send_byte(move_byte());
                    if (wheel)
                        send_byte(8'($urandom_range(0, 255)));
                    sent += wheel ? 4 : 3;
                end
            end
            // send up to two more bytes, which may leave a partial packet open across the next size change
            repeat ($urandom_range(0, 2))
                send_byte(8'($urandom_range(0, 255)));
            i_valid <= 1'b0;
        end

        calm <= 1'b0;
        drain_events();
        repeat (20) @(posedge i_clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
